### hdl/nts_pkg.sv
package nts_pkg;

  localparam int ValueW     = 32;
  localparam int NumDigits  = 10;
  localparam int BcdW       = 4 * NumDigits;
  localparam int WorkW      = BcdW + ValueW;
  localparam int StepsPerSt = 8;
  localparam int DabbleSts  = ValueW / StepsPerSt;
  localparam int AddrW      = 4;
  localparam int SegW       = 8;

  localparam logic [SegW-1:0]  SegMinus = 8'h01;
  localparam logic [SegW-1:0]  SegDot   = 8'h80;
  localparam logic [AddrW-1:0] DotIdx   = 4'd2;

  // work word: {bcd digits, binary bits still to shift in}
  typedef struct packed {
    logic             chip;
    logic             neg;
    logic [WorkW-1:0] work;
  } nts_item_t;

  function automatic logic [SegW-1:0] seg_of(input logic [3:0] d);
    logic [SegW-1:0] s;
    unique case (d)
      4'd0:    s = 8'h7e;
      4'd1:    s = 8'h30;
      4'd2:    s = 8'h6d;
      4'd3:    s = 8'h79;
      4'd4:    s = 8'h33;
      4'd5:    s = 8'h5b;
      4'd6:    s = 8'h5f;
      4'd7:    s = 8'h70;
      4'd8:    s = 8'h7f;
      4'd9:    s = 8'h7b;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // shift-and-add-3 over one slice of the binary bits
  function automatic logic [WorkW-1:0] dabble_slice(input logic [WorkW-1:0] w_in);
    logic [WorkW-1:0] w;
    w = w_in;
    for (int s = 0; s < StepsPerSt; s++) begin
      for (int i = 0; i < NumDigits; i++) begin
        if (w[ValueW + 4*i +: 4] >= 4'd5) begin
          w[ValueW + 4*i +: 4] = w[ValueW + 4*i +: 4] + 4'd3;
        end
      end
      w = {w[WorkW-2:0], 1'b0};
    end
    return w;
  endfunction

endpackage

### hdl/number_to_segment_writes.sv
// Number to seven-segment driver register writes.
//
// Input channel (in_valid / in_stall, in_chip, in_value): one signed number
// per transfer, aimed at one of two driver chips. Output channel (out_valid /
// out_stall): one register write per transfer, digit address plus segment
// byte, least significant digit at address 1, out_last set on the final write
// of a number. cfg_wr_en / cfg_wr_data set display_mode (0 signed with minus
// code, 1 dot on digit three, or two for 1 to 9); write it only while idle.
//
// The first write of a number passes through the magnitude stage, four BCD
// conversion stages of eight shift-add-3 steps each, the emitter load and
// the output register.
// Throughput: one write per cycle unless stalled; a number of n writes (1 to
// 11) holds the emitter for n writes, so the emitter sets the sustained rate.
// The pipeline ahead of it takes a new number every cycle until it fills.
//
// Reset (synchronous, rst_n low) empties every stage and sets signed mode.
// A stall on the output holds the write in place; the back-pressure runs up
// the stages and raises in_stall once they are full. Nothing is lost.
module number_to_segment_writes (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_chip,
  input  logic signed [31:0]          in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_chip_out,
  output logic [nts_pkg::AddrW-1:0]   out_register_address,
  output logic [nts_pkg::SegW-1:0]    out_segment_data,
  output logic                        out_last
);
  import nts_pkg::*;

  logic display_mode_r;

  // stage 0 is the magnitude stage, 1..DabbleSts the BCD conversion
  nts_item_t st_item  [DabbleSts+1];
  logic      st_valid [DabbleSts+1];
  logic      st_ready [DabbleSts+1];
  logic      mag_in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      display_mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      display_mode_r <= cfg_wr_data;
    end
  end

  assign in_stall = !mag_in_ready;

  nts_mag_stage u_mag (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (mag_in_ready),
    .in_chip   (in_chip),
    .in_value  (in_value),
    .out_valid (st_valid[0]),
    .out_ready (st_ready[0]),
    .out_item  (st_item[0])
  );

  // st_ready[i] is the ready of whatever consumes stage i
  for (genvar g = 0; g < DabbleSts; g++) begin : g_dabble
    nts_dabble_stage u_dabble (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (st_valid[g]),
      .in_ready  (st_ready[g]),
      .in_item   (st_item[g]),
      .out_valid (st_valid[g+1]),
      .out_ready (st_ready[g+1]),
      .out_item  (st_item[g+1])
    );
  end

  nts_emit u_emit (
    .clk                  (clk),
    .rst_n                (rst_n),
    .display_mode         (display_mode_r),
    .in_valid             (st_valid[DabbleSts]),
    .in_ready             (st_ready[DabbleSts]),
    .in_item              (st_item[DabbleSts]),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_chip_out         (out_chip_out),
    .out_register_address (out_register_address),
    .out_segment_data     (out_segment_data),
    .out_last             (out_last)
  );
endmodule

### hdl/nts_mag_stage.sv
module nts_mag_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_chip,
  input  logic signed [31:0]   in_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output nts_pkg::nts_item_t   out_item
);
  import nts_pkg::*;

  logic             valid_r;
  nts_item_t        item_r;
  logic [ValueW-1:0] mag;

  assign in_ready = !valid_r || out_ready;
  // most negative input wraps to its unsigned magnitude
  assign mag = in_value[ValueW-1] ? (~in_value + 32'd1) : in_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r.chip <= in_chip;
      item_r.neg  <= in_value[ValueW-1];
      item_r.work <= {{BcdW{1'b0}}, mag};
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;
endmodule

### hdl/nts_dabble_stage.sv
module nts_dabble_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  nts_pkg::nts_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output nts_pkg::nts_item_t out_item
);
  import nts_pkg::*;

  logic      valid_r;
  nts_item_t item_r;

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r.chip <= in_item.chip;
      item_r.neg  <= in_item.neg;
      item_r.work <= dabble_slice(in_item.work);
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;
endmodule

### hdl/nts_emit.sv
module nts_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        display_mode,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  nts_pkg::nts_item_t          in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_chip_out,
  output logic [nts_pkg::AddrW-1:0]   out_register_address,
  output logic [nts_pkg::SegW-1:0]    out_segment_data,
  output logic                        out_last
);
  import nts_pkg::*;

  logic             busy_r;
  logic             chip_r;
  logic             mode_r;
  logic [BcdW-1:0]  bcd_r;
  logic [AddrW-1:0] ndig_r;
  logic [AddrW-1:0] cnt_r;
  logic [AddrW-1:0] k_r;

  logic             ov_r;
  logic             ochip_r;
  logic [AddrW-1:0] oaddr_r;
  logic [SegW-1:0]  odata_r;
  logic             olast_r;

  logic             adv, emit, done, load;
  logic [BcdW-1:0]  ld_bcd;
  logic [AddrW-1:0] ld_nd, ld_ndig, ld_cnt;
  logic             ld_zero;
  logic [SegW-1:0]  cur_data;

  assign adv  = !ov_r || !out_stall;
  assign emit = busy_r && adv;
  assign done = emit && ((k_r + 4'd1) == cnt_r);
  assign in_ready = !busy_r || done;
  assign load = in_ready && in_valid;

  // digit count and write count of the incoming item
  always_comb begin
    ld_bcd = in_item.work[WorkW-1:ValueW];
    ld_nd  = 4'd1;
    for (int i = 1; i < NumDigits; i++) begin
      if (ld_bcd[4*i +: 4] != 4'd0) begin
        ld_nd = 4'(i + 1);
      end
    end
    ld_zero = (ld_bcd == '0);
    // dot-mode zero shows two plain zeros before the '0.' digit
    ld_ndig = (display_mode && ld_zero) ? 4'd2 : ld_nd;
    if (display_mode) begin
      ld_cnt = (ld_ndig < 4'd3) ? ld_ndig + 4'd1 : ld_ndig;
    end else begin
      ld_cnt = ld_nd + {3'b000, in_item.neg};
    end
  end

  always_comb begin
    if (k_r < ndig_r) begin
      cur_data = seg_of(bcd_r[3:0]);
    end else begin
      cur_data = mode_r ? seg_of(4'd0) : SegMinus;
    end
    if (mode_r && (k_r == DotIdx || k_r >= ndig_r)) begin
      cur_data = cur_data | SegDot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
      end else if (done) begin
        busy_r <= 1'b0;
      end
      if (adv) begin
        ov_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chip_r <= in_item.chip;
      mode_r <= display_mode;
      bcd_r  <= ld_bcd;
      ndig_r <= ld_ndig;
      cnt_r  <= ld_cnt;
      k_r    <= '0;
    end else if (emit) begin
      bcd_r <= {4'd0, bcd_r[BcdW-1:4]};
      k_r   <= k_r + 4'd1;
    end
    if (emit) begin
      ochip_r <= chip_r;
      oaddr_r <= k_r + 4'd1;
      odata_r <= cur_data;
      olast_r <= (k_r + 4'd1) == cnt_r;
    end
  end

  assign out_valid            = ov_r;
  assign out_chip_out         = ochip_r;
  assign out_register_address = oaddr_r;
  assign out_segment_data     = odata_r;
  assign out_last             = olast_r;
endmodule

### hdl/nts_checker.sv
module nts_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_chip_out,
  input logic [3:0] out_register_address,
  input logic [7:0] out_segment_data,
  input logic       out_last
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a stalled write holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_register_address)
      && $stable(out_segment_data) && $stable(out_last) && $stable(out_chip_out))
    else $error("stalled write changed");

  // addresses stay within the digit registers
  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_register_address != 4'd0 && out_register_address <= 4'd11)
    else $error("address out of range");

  // a run of writes continues at once, next address, same chip
  a_run_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid
      && out_register_address == $past(out_register_address) + 4'd1
      && out_chip_out == $past(out_chip_out))
    else $error("broken write run");

endmodule

bind number_to_segment_writes nts_checker u_nts_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_chip_out         (out_chip_out),
  .out_register_address (out_register_address),
  .out_segment_data     (out_segment_data),
  .out_last             (out_last)
);
